// ===== rtl/assert_macros.svh =====
// Assertion helpers for the string escape decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SED_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
`timescale 1ns / 1ps

package sed_pkg;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_X  = 8'h78;

  localparam logic [20:0] MAX_CP_RESET = 21'h10FFFF;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;

  // Run queue between front and back
  localparam int QDEPTH = 4;
  localparam int QADDR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SEMI   = 2'd1,
    ST_BAD_CODE  = 2'd2,
    ST_TRAIL_BSL = 2'd3
  } status_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nb;     // decoded bytes, 0 to 4
    logic            tail;   // extra end marker beat with status
    logic            eol;    // literal ends with this run
    status_t         st;
  } run_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
  endfunction

  // {digit valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    hex_digit = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      hex_digit = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      hex_digit = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      hex_digit = {1'b1, d[3:0]};
    end
  endfunction

endpackage

// ===== rtl/string_escape_decoder_top.sv =====
`timescale 1ns / 1ps
// String escape decoder: body bytes of a quoted literal in, decoded bytes out.
// Input channel in_valid/in_ready carries in_byte and last_byte, one byte a beat.
// Output channel out_valid/out_ready carries one result a beat: out_byte,
// byte_valid, status, end_of_literal (final beat of a literal) and last_of_run
// (final beat caused by one input byte). A non-zero status ends the literal
// and the consumer drops the bytes already taken for it.
// cfg_we writes cfg_wdata into the largest accepted hex escape value.
// The first result of a byte is written into the run queue and then loaded
// into the output register. Throughput: one input byte per cycle while each
// byte yields at most one beat and the receiver keeps up. The output register
// sends one beat per cycle while out_ready is high; a byte with up to four
// beats holds it until all are sent. A four-entry run queue between decoder
// and output stage absorbs these bursts; in_ready falls only when that queue
// is full. Reset clears decoder state, the queue and out_valid and sets the
// limit to 0x10FFFF. When the receiver stalls, the current beat holds, the
// queue fills and then the input is held off; no beat is lost.

`include "assert_macros.svh"

module string_escape_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [1:0]  status,
  output logic        end_of_literal,
  output logic        last_of_run
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  sed_pkg::run_t q_wdata;
  sed_pkg::run_t q_head;

  sed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  sed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sed_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .status         (status),
    .end_of_literal (end_of_literal),
    .last_of_run    (last_of_run)
  );

  // Checks
  `SED_ASSERT(a_no_push_full, clk, rst, q_push |-> !q_full, "run pushed into full queue")
  `SED_ASSERT(a_no_pop_empty, clk, rst, q_pop |-> !q_empty, "run popped from empty queue")
  `SED_ASSERT(a_status_on_end, clk, rst, (out_valid && status != 2'd0) |-> (end_of_literal && !byte_valid), "error status on a data beat")
  `SED_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "output valid after reset")

endmodule

// ===== rtl/sed_front.sv =====
`timescale 1ns / 1ps

module sed_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [20:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              last_byte,
  input  logic              q_full,
  output logic              q_push,
  output sed_pkg::run_t     q_data
);

  typedef enum logic [2:0] {
    M_NORMAL,
    M_ESC,
    M_WS,
    M_HEX,
    M_ERR
  } mode_t;

  mode_t            mode, mode_next;
  logic [20:0]      max_cp;
  logic [20:0]      hex_accum, hex_accum_next;
  logic             hex_bad, hex_bad_next;
  logic             hex_seen, hex_seen_next;
  logic             pending_cr, pending_cr_next;
  sed_pkg::status_t err, err_next;

  logic             accept;
  logic             run_plain;
  logic [2:0]       nb;
  logic [3:0][7:0]  bvec;
  logic             tail;
  sed_pkg::status_t st;
  logic [4:0]       hd;
  logic [24:0]      hex_acc_step;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hd           = sed_pkg::hex_digit(in_byte);
  assign hex_acc_step = {hex_accum, 4'b0} + {21'b0, hd[3:0]};

  // Byte classification and next state
  always_comb begin
    mode_next       = mode;
    hex_accum_next  = hex_accum;
    hex_bad_next    = hex_bad;
    hex_seen_next   = hex_seen;
    pending_cr_next = pending_cr;
    err_next        = err;
    run_plain       = 1'b0;
    nb              = 3'd0;
    bvec            = '0;
    tail            = 1'b0;
    st              = sed_pkg::ST_OK;

    unique case (mode)
      M_NORMAL: run_plain = 1'b1;
      M_ESC: begin
        mode_next = M_NORMAL;
        unique case (in_byte)
          sed_pkg::CH_LOW_A: begin bvec[0] = sed_pkg::CH_BEL; nb = 3'd1; end
          sed_pkg::CH_LOW_B: begin bvec[0] = sed_pkg::CH_BS;  nb = 3'd1; end
          sed_pkg::CH_LOW_T: begin bvec[0] = sed_pkg::CH_HT;  nb = 3'd1; end
          sed_pkg::CH_LOW_N: begin bvec[0] = sed_pkg::CH_LF;  nb = 3'd1; end
          sed_pkg::CH_LOW_R: begin bvec[0] = sed_pkg::CH_CR;  nb = 3'd1; end
          sed_pkg::CH_LOW_X: begin
            mode_next      = M_HEX;
            hex_accum_next = '0;
            hex_bad_next   = 1'b0;
            hex_seen_next  = 1'b0;
          end
          default: begin
            if (sed_pkg::is_space(in_byte)) begin
              mode_next = M_WS;
            end else begin
              bvec[0] = in_byte;
              nb      = 3'd1;
            end
          end
        endcase
      end
      M_WS: begin
        if (!sed_pkg::is_space(in_byte)) begin
          mode_next = M_NORMAL;
          run_plain = 1'b1;
        end
      end
      M_HEX: begin
        if (in_byte == sed_pkg::CH_SEMI) begin
          if (hex_bad || !hex_seen || hex_accum > max_cp ||
              (hex_accum >= sed_pkg::SURR_LO && hex_accum <= sed_pkg::SURR_HI)) begin
            err_next  = sed_pkg::ST_BAD_CODE;
            mode_next = M_ERR;
          end else begin
            mode_next = M_NORMAL;
            // UTF-8 encoding of the accumulated code point
            if (hex_accum < 21'h80) begin
              bvec[0] = hex_accum[7:0];
              nb      = 3'd1;
            end else if (hex_accum < 21'h800) begin
              bvec[0] = {3'b110, hex_accum[10:6]};
              bvec[1] = {2'b10, hex_accum[5:0]};
              nb      = 3'd2;
            end else if (hex_accum < 21'h10000) begin
              bvec[0] = {4'b1110, hex_accum[15:12]};
              bvec[1] = {2'b10, hex_accum[11:6]};
              bvec[2] = {2'b10, hex_accum[5:0]};
              nb      = 3'd3;
            end else begin
              bvec[0] = {5'b11110, hex_accum[20:18]};
              bvec[1] = {2'b10, hex_accum[17:12]};
              bvec[2] = {2'b10, hex_accum[11:6]};
              bvec[3] = {2'b10, hex_accum[5:0]};
              nb      = 3'd4;
            end
          end
        end else if (!hd[4]) begin
          hex_bad_next = 1'b1;
        end else begin
          hex_seen_next = 1'b1;
          if (hex_acc_step > {4'b0, max_cp}) begin
            hex_bad_next = 1'b1;
          end else begin
            hex_accum_next = hex_acc_step[20:0];
          end
        end
      end
      M_ERR: ;
      default: ;
    endcase

    // Plain byte: held CR (folded into LF), then the byte unless backslash or CR
    if (run_plain) begin
      if (pending_cr && in_byte == sed_pkg::CH_LF) begin
        pending_cr_next = 1'b0;
        bvec[nb[1:0]]   = sed_pkg::CH_LF;
        nb              = nb + 3'd1;
      end else begin
        if (pending_cr) begin
          pending_cr_next = 1'b0;
          bvec[nb[1:0]]   = sed_pkg::CH_CR;
          nb              = nb + 3'd1;
        end
        if (in_byte == sed_pkg::CH_BSLASH) begin
          mode_next = M_ESC;
        end else if (in_byte == sed_pkg::CH_CR) begin
          pending_cr_next = 1'b1;
        end else begin
          bvec[nb[1:0]] = in_byte;
          nb            = nb + 3'd1;
        end
      end
    end

    // End of literal: status, flush held CR, clear state
    if (last_byte) begin
      if (err_next == sed_pkg::ST_OK) begin
        if (mode_next == M_ESC) begin
          err_next = sed_pkg::ST_TRAIL_BSL;
        end else if (mode_next == M_HEX) begin
          err_next = sed_pkg::ST_NO_SEMI;
        end else if (pending_cr_next) begin
          bvec[nb[1:0]] = sed_pkg::CH_CR;
          nb            = nb + 3'd1;
        end
      end
      st   = err_next;
      tail = (err_next != sed_pkg::ST_OK) || (nb == 3'd0);
      mode_next       = M_NORMAL;
      hex_accum_next  = '0;
      hex_bad_next    = 1'b0;
      hex_seen_next   = 1'b0;
      pending_cr_next = 1'b0;
      err_next        = sed_pkg::ST_OK;
    end
  end

  assign q_push      = accept && ((nb != 3'd0) || tail);
  assign q_data.bytes = bvec;
  assign q_data.nb    = nb;
  assign q_data.tail  = tail;
  assign q_data.eol   = last_byte;
  assign q_data.st    = st;

  // Decoder state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      hex_accum  <= '0;
      hex_bad    <= 1'b0;
      hex_seen   <= 1'b0;
      pending_cr <= 1'b0;
      err        <= sed_pkg::ST_OK;
      max_cp     <= sed_pkg::MAX_CP_RESET;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        hex_accum  <= hex_accum_next;
        hex_bad    <= hex_bad_next;
        hex_seen   <= hex_seen_next;
        pending_cr <= pending_cr_next;
        err        <= err_next;
      end
      if (cfg_we) begin
        max_cp <= cfg_wdata;
      end
    end
  end

endmodule

// ===== rtl/sed_queue.sv =====
`timescale 1ns / 1ps

module sed_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sed_pkg::run_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sed_pkg::run_t head
);

  sed_pkg::run_t                 entries [sed_pkg::QDEPTH];
  logic [sed_pkg::QADDR_W-1:0]   wr_ptr;
  logic [sed_pkg::QADDR_W-1:0]   rd_ptr;
  logic [sed_pkg::QCNT_W-1:0]    count;

  assign full  = (count == sed_pkg::QCNT_W'(sed_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Run storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sed_back.sv =====
`timescale 1ns / 1ps

module sed_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  sed_pkg::run_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic [1:0]    status,
  output logic          end_of_literal,
  output logic          last_of_run
);

  logic [2:0] idx;
  logic [2:0] total;
  logic       is_last;
  logic       load;
  logic       is_byte;

  assign total   = q_head.nb + {2'b0, q_head.tail};
  assign is_last = (idx == total - 3'd1);
  assign is_byte = (idx < q_head.nb);
  assign load    = !q_empty && (!out_valid || out_ready);
  assign q_pop   = load && is_last;

  // Output register, one result beat per cycle while the receiver is ready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Beat payload
  always_ff @(posedge clk) begin
    if (load) begin
      last_of_run <= is_last;
      if (is_byte) begin
        out_byte       <= q_head.bytes[idx[1:0]];
        byte_valid     <= 1'b1;
        status         <= sed_pkg::ST_OK;
        end_of_literal <= q_head.eol && !q_head.tail && is_last;
      end else begin
        out_byte       <= 8'h00;
        byte_valid     <= 1'b0;
        status         <= q_head.st;
        end_of_literal <= 1'b1;
      end
    end
  end

endmodule

// ===== sim/string_escape_decoder_top_test.sv =====
`timescale 1ns / 1ps

module string_escape_decoder_top_test;
  import sed_pkg::*;

  localparam int STALL_LIMIT = 500;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 18;

  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_UP_A   = 8'h41;

  typedef enum logic [2:0] {DM_PLAIN, DM_ESCAPE, DM_SKIP_WS, DM_HEX, DM_DEAD} dec_mode_t;

  // One output beat
  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    status_t    st;
    logic       eol;
    logic       run_end;
  } beat_t;

  // One directed input byte, with its single beat typed in where obvious
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] want_byte;
    logic       want_ok;
    status_t    want_st;
  } probe_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [20:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [1:0]  status;
  logic        end_of_literal;
  logic        last_of_run;

  // Decoder state as predicted
  dec_mode_t   mode;
  logic [20:0] code_acc;
  logic        code_bad;
  logic        code_seen;
  logic        cr_held;
  status_t     lit_error;
  logic [20:0] cp_limit;

  beat_t decoded_run[$];
  beat_t pending_beats[$];
  int    mismatches = 0;
  int    items_sent = 0;
  bit    allow_gaps = 1'b1;
  bit    gaps_on = 1'b0;

  probe_t probes[28] = '{
    '{8'h41,     1'b1, 1'b1, 8'h41, 1'b1, ST_OK},         // single byte literal
    '{8'h00,     1'b0, 1'b1, 8'h00, 1'b1, ST_OK},
    '{8'hFF,     1'b0, 1'b1, 8'hFF, 1'b1, ST_OK},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_LOW_N,  1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_CR,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},         // CR LF folds to LF
    '{CH_LF,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_CR,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},         // lone CR
    '{8'h5A,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},         // escaped whitespace run
    '{CH_SPACE,  1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{8'h71,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},         // four byte UTF-8
    '{CH_LOW_X,  1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{8'h31,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{8'h30,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{8'h30,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{8'h30,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{8'h30,     1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_SEMI,   1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_BSLASH, 1'b1, 1'b1, 8'h00, 1'b0, ST_TRAIL_BSL},  // trailing backslash
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},         // hex escape, no digits
    '{CH_LOW_X,  1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_SEMI,   1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{8'h6B,     1'b1, 1'b1, 8'h00, 1'b0, ST_BAD_CODE},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},         // no semicolon
    '{CH_LOW_X,  1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{CH_LOW_A,  1'b1, 1'b1, 8'h00, 1'b0, ST_NO_SEMI}
  };

  string_escape_decoder_top uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .status         (status),
    .end_of_literal (end_of_literal),
    .last_of_run    (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- queue helpers

  function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void append_beat(ref beat_t q[$], input beat_t b);
    q.insert(q.size(), b);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic bit blank_char(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9) return int'(c - CH_DIGIT0);
    if (c >= CH_LOW_A && c <= CH_LOW_A + 8'd5) return int'(c - CH_LOW_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_A + 8'd5) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic void clear_literal();
    mode = DM_PLAIN;
    code_acc = '0;
    code_bad = 1'b0;
    code_seen = 1'b0;
    cr_held = 1'b0;
    lit_error = ST_OK;
  endfunction

  function automatic void put_decoded(input logic [7:0] b);
    append_beat(decoded_run, '{b, 1'b1, ST_OK, 1'b0, 1'b0});
  endfunction

  function automatic void put_code_point(input logic [20:0] v);
    if (v < 21'h80) begin
      put_decoded(v[7:0]);
    end else if (v < 21'h800) begin
      put_decoded({3'b110, v[10:6]});
      put_decoded({2'b10, v[5:0]});
    end else if (v < 21'h10000) begin
      put_decoded({4'b1110, v[15:12]});
      put_decoded({2'b10, v[11:6]});
      put_decoded({2'b10, v[5:0]});
    end else begin
      put_decoded({5'b11110, v[20:18]});
      put_decoded({2'b10, v[17:12]});
      put_decoded({2'b10, v[11:6]});
      put_decoded({2'b10, v[5:0]});
    end
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    // a held CR either merges with LF or goes out on its own
    if (cr_held) begin
      cr_held = 1'b0;
      if (c == CH_LF) begin
        put_decoded(CH_LF);
        return;
      end
      put_decoded(CH_CR);
    end
    if (c == CH_BSLASH) mode = DM_ESCAPE;
    else if (c == CH_CR) cr_held = 1'b1;
    else put_decoded(c);
  endfunction

  function automatic void take_escaped(input logic [7:0] c);
    mode = DM_PLAIN;
    case (c)
      CH_LOW_A: put_decoded(CH_BEL);
      CH_LOW_B: put_decoded(CH_BS);
      CH_LOW_T: put_decoded(CH_HT);
      CH_LOW_N: put_decoded(CH_LF);
      CH_LOW_R: put_decoded(CH_CR);
      CH_LOW_X: begin
        mode = DM_HEX;
        code_acc = '0;
        code_bad = 1'b0;
        code_seen = 1'b0;
      end
      default: begin
        if (blank_char(c)) mode = DM_SKIP_WS;
        else put_decoded(c);
      end
    endcase
  endfunction

  function automatic void take_hex(input logic [7:0] c);
    int nib;
    logic [24:0] grown;
    if (c == CH_SEMI) begin
      if (code_bad || !code_seen || code_acc > cp_limit ||
          (code_acc >= SURR_LO && code_acc <= SURR_HI)) begin
        lit_error = ST_BAD_CODE;
        mode = DM_DEAD;
      end else begin
        put_code_point(code_acc);
        mode = DM_PLAIN;
      end
      return;
    end
    nib = hex_nibble(c);
    if (nib < 0) begin
      code_bad = 1'b1;
      return;
    end
    code_seen = 1'b1;
    // an overflowing digit marks the escape bad and leaves the sum alone
    grown = {code_acc, 4'h0} + 25'(nib);
    if (grown > {4'h0, cp_limit}) code_bad = 1'b1;
    else code_acc = grown[20:0];
  endfunction

  // Beats caused by one input byte, left in decoded_run
  function automatic void decode_byte(input logic [7:0] c, input logic last);
    int tail;
    decoded_run.delete();
    case (mode)
      DM_PLAIN:  take_plain(c);
      DM_ESCAPE: take_escaped(c);
      DM_SKIP_WS: begin
        if (!blank_char(c)) begin
          mode = DM_PLAIN;
          take_plain(c);
        end
      end
      DM_HEX:    take_hex(c);
      default:   ;
    endcase
    if (last) begin
      if (lit_error == ST_OK) begin
        if (mode == DM_ESCAPE) lit_error = ST_TRAIL_BSL;
        else if (mode == DM_HEX) lit_error = ST_NO_SEMI;
        else if (cr_held) put_decoded(CH_CR);
      end
      if (lit_error == ST_OK && decoded_run.size() > 0) begin
        tail = decoded_run.size() - 1;
        decoded_run[tail].eol = 1'b1;
      end else begin
        append_beat(decoded_run, '{8'h00, 1'b0, lit_error, 1'b1, 1'b0});
      end
      clear_literal();
    end
    if (decoded_run.size() > 0) begin
      tail = decoded_run.size() - 1;
      decoded_run[tail].run_end = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] c, input logic last, input bit typed,
                           input beat_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= c;
    last_byte <= last;
    // ready is sampled mid-cycle; the beat is taken at the next rising edge
    do @(negedge clk); while (!in_ready);
    decode_byte(c, last);
    if (typed) append_beat(pending_beats, want);
    else foreach (decoded_run[i]) append_beat(pending_beats, decoded_run[i]);
    @(posedge clk);
  endtask

  task automatic set_limit(input logic [20:0] v);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // the last byte may have caused no beat and still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cp_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_hex_digits(ref logic [7:0] q[$], input logic [20:0] v);
    int ndig;
    logic [3:0] nib;
    ndig = 1;
    while (ndig < 6 && (v >> (4 * ndig)) != 0) ndig++;
    ndig += $urandom_range(0, 2);
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = 4'(v >> (4 * i));
      if (nib < 4'd10) append_byte(q, CH_DIGIT0 + nib);
      else append_byte(q, ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + nib - 8'd10);
    end
  endfunction

  // One random literal, mostly well formed, with some noise and broken escapes
  task automatic send_literal();
    logic [7:0] body[$];
    logic [7:0] named[8];
    logic [7:0] blanks[6];
    logic [7:0] junk;
    logic [20:0] cp;
    int pieces;
    int pick;
    bit stop;
    named = '{CH_LOW_A, CH_LOW_B, CH_LOW_T, CH_LOW_N, CH_LOW_R, CH_BSLASH, CH_DQUOTE, CH_BAR};
    blanks = '{CH_SPACE, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR};
    gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
    pieces = $urandom_range(1, 5);
    stop = 1'b0;
    for (int p = 0; p < pieces && !stop; p++) begin
      pick = $urandom_range(0, 39);
      if (pick < 20) begin
        append_byte(body, 8'($urandom_range(0, 255)));
      end else if (pick == 20) begin
        append_byte(body, CH_CR);
        append_byte(body, CH_LF);
      end else if (pick == 21) begin
        append_byte(body, CH_CR);
      end else if (pick < 27) begin
        append_byte(body, CH_BSLASH);
        append_byte(body, named[$urandom_range(0, 7)]);
      end else if (pick == 27) begin
        append_byte(body, CH_BSLASH);
        append_byte(body, 8'($urandom_range(0, 255)));
      end else if (pick < 30) begin
        append_byte(body, CH_BSLASH);
        repeat ($urandom_range(1, 3)) append_byte(body, blanks[$urandom_range(0, 5)]);
      end else if (pick < 36) begin
        // hex escape spread over all UTF-8 lengths, surrogates and overlimit
        case ($urandom_range(0, 9))
          0, 1:    cp = 21'($urandom_range(0, 'h7F));
          2, 3:    cp = 21'($urandom_range('h80, 'h7FF));
          4, 5:    cp = 21'($urandom_range('h800, 'hFFFF));
          6, 7:    cp = 21'($urandom_range('h10000, 'h1FFFFF));
          8:       cp = 21'($urandom_range('hD800, 'hDFFF));
          default: cp = 21'($urandom_range(0, 'h1FFFFF));
        endcase
        if (cp > cp_limit && $urandom_range(0, 3) != 0)
          cp = 21'(32'(cp) % (32'(cp_limit) + 1));
        append_byte(body, CH_BSLASH);
        append_byte(body, CH_LOW_X);
        add_hex_digits(body, cp);
        append_byte(body, CH_SEMI);
      end else if (pick < 38) begin
        // bad hex: no digits, or a stray byte among them
        append_byte(body, CH_BSLASH);
        append_byte(body, CH_LOW_X);
        if ($urandom_range(0, 1)) begin
          do junk = 8'($urandom_range(0, 255));
          while (hex_nibble(junk) >= 0 || junk == CH_SEMI);
          add_hex_digits(body, 21'($urandom_range(0, 'hFFF)));
          append_byte(body, junk);
        end
        append_byte(body, CH_SEMI);
      end else if (pick == 38) begin
        append_byte(body, CH_BSLASH);
        append_byte(body, CH_LOW_X);
        add_hex_digits(body, 21'($urandom_range(0, 'hFFFF)));
        stop = 1'b1;
      end else begin
        append_byte(body, CH_BSLASH);
        stop = 1'b1;
      end
    end
    foreach (body[i]) send_byte(body[i], i == body.size() - 1, 1'b0, '0);
    items_sent += body.size();
  endtask

  // Receiver: random stall bursts while gaps are on
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) stall_left--;
      else if (gaps_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      out_ready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Outputs are stable mid-cycle; the beat is taken at the next rising edge
  always @(negedge clk) begin
    beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        $display("%0t: beat expected none, got out_byte %0h byte_valid %0b status %0d eol %0b",
                 $time, out_byte, byte_valid, status, end_of_literal);
      end else begin
        want = pending_beats.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("byte_valid", want.data_ok, byte_valid);
        check_field("status", want.st, status);
        check_field("end_of_literal", want.eol, end_of_literal);
        check_field("last_of_run", want.run_end, last_of_run);
      end
    end
  end

  // Watchdog: too long without any beat moving on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(negedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [20:0] plan[7];
    beat_t want;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_byte <= '0;
    last_byte <= 1'b0;
    cp_limit = MAX_CP_RESET;
    clear_literal();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed bytes at the reset limit
    set_limit(MAX_CP_RESET);
    gaps_on = 1'b1;
    foreach (probes[i]) begin
      want = '{probes[i].want_byte, probes[i].want_ok, probes[i].want_st, probes[i].last, 1'b1};
      send_byte(probes[i].data, probes[i].last, probes[i].typed, want);
    end

    // random literals under a range of limits; the final phase runs flat out
    plan = '{MAX_CP_RESET, 21'd127, 21'h1FFFFF, 21'h00FFFF, 21'h0007FF,
             21'($urandom_range(127, 'h10FFFF)), MAX_CP_RESET};
    foreach (plan[i]) begin
      if (i == 6) allow_gaps = 1'b0;
      set_limit(plan[i]);
      items_sent = 0;
      while (items_sent < ITEMS_PER_PHASE) send_literal();
    end

    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
